>>> design/tmqg_pkg.sv
package tmqg_pkg;

	// Field widths
	localparam int W_ID   = 17;
	localparam int W_SLOT = 18;
	localparam int W_POS  = 17;
	localparam int W_TU   = 17;
	localparam int W_TV   = 25;
	localparam int W_CFG  = 9;
	localparam int W_IDX  = 2;

	// Atlas split: 16-bit tile number over a divisor of at most 256
	localparam int W_QUO = 16;
	localparam int W_REM = 8;

	// Largest tile size and atlas width taken as is
	localparam int unsigned CFG_LIMIT = 256;

	// Configuration register indexes
	localparam logic [W_IDX-1:0] CFG_MAP_COLUMNS   = 2'd0;
	localparam logic [W_IDX-1:0] CFG_MAP_ROWS      = 2'd1;
	localparam logic [W_IDX-1:0] CFG_TILE_SIZE     = 2'd2;
	localparam logic [W_IDX-1:0] CFG_ATLAS_COLUMNS = 2'd3;

	// Corner codes, in emission order
	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	// Multiplier passes of one tile
	typedef enum logic [2:0] {
		OP_ROW_COLS = 3'd0,
		OP_COL_TS   = 3'd1,
		OP_ROW_TS   = 3'd2,
		OP_TU_TS    = 3'd3,
		OP_TV_TS    = 3'd4
	} mul_op_t;

	localparam logic [2:0] NUM_OPS = 3'd5;

	typedef struct packed {
		logic    valid;
		mul_op_t op;
	} mul_tag_t;

	// Zero acts as one, anything above hi acts as hi
	function automatic logic [W_CFG-1:0] clamp_cfg(logic [W_CFG-1:0] v, int unsigned hi);
		logic [W_CFG-1:0] r;
		if (v == '0) begin
			r = W_CFG'(1);
		end else if (32'(v) > hi) begin
			r = W_CFG'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> design/tile_map_quad_generator.sv
// Tile map quad generator. Each accepted tile number yields four corner vertices (top-left,
// top-right, bottom-right, bottom-left) carrying vertex slot, screen position, atlas texture
// coordinate, a visible flag and a last-corner flag. Tiles are walked column by column and
// down the rows within each column; the walk wraps after the last tile and restarts whenever
// map_columns or map_rows is written. A tile is accepted, split by the bit-serial divider into
// atlas column and row, handed over, run through the shared registered multiplier for five
// products, and sent as four output beats. in_ready is high only between tiles. A negative
// tile number gives an empty tile: zero texture coordinates, visible low.
// The configuration port is always ready; writes belong in idle time.
module tile_map_quad_generator #(
	parameter int MAX_MAP_DIM = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmqg_pkg::W_IDX-1:0]         cfg_index,
	input  logic [tmqg_pkg::W_CFG-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tmqg_pkg::W_ID-1:0]   tile_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tmqg_pkg::W_SLOT-1:0]        vertex_slot,
	output logic [tmqg_pkg::W_POS-1:0]         pos_x,
	output logic [tmqg_pkg::W_POS-1:0]         pos_y,
	output logic [tmqg_pkg::W_TU-1:0]          tex_u,
	output logic [tmqg_pkg::W_TV-1:0]          tex_v,
	output logic                               visible,
	output logic                               last_corner
);
	import tmqg_pkg::*;

	localparam int CNT_W  = $clog2(MAX_MAP_DIM);
	localparam int AW     = (CNT_W > W_QUO) ? CNT_W : W_QUO;
	localparam int PW     = AW + W_CFG;
	localparam int BASE_W = W_SLOT - 2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_MUL  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t            state_q;
	logic [W_CFG-1:0]  map_cols_q, map_rows_q, tile_size_q, atlas_cols_q;
	logic [W_CFG-1:0]  cols_eff, rows_eff, ts_eff, ac_eff;
	logic [CNT_W-1:0]  col_cnt_q, row_cnt_q;
	logic [CNT_W:0]    col_next, row_next;
	logic [CNT_W-1:0]  item_col_q, item_row_q;
	logic              empty_q;
	logic              in_accept, cfg_accept;
	logic              div_done;
	logic [W_QUO-1:0]  div_quo;
	logic [W_REM-1:0]  div_rem;
	logic [2:0]        step_q;
	mul_tag_t          issue, mul_tag;
	logic [PW-1:0]     mul_prod;
	logic [BASE_W-1:0] base_q;
	logic [W_POS-1:0]  px_q, py_q;
	logic [W_TU-1:0]   tu_ts_q;
	logic [W_TV-1:0]   tv_ts_q;
	logic [1:0]        corner_q;
	logic              emit_load;
	logic              dx, dy;
	logic [W_CFG-1:0]  ts_x, ts_y;
	logic              out_valid_q;
	logic [W_SLOT-1:0] slot_q;
	logic [W_POS-1:0]  pos_x_q, pos_y_q;
	logic [W_TU-1:0]   tex_u_q;
	logic [W_TV-1:0]   tex_v_q;
	logic              visible_q, last_q;

	assign cols_eff = clamp_cfg(map_cols_q, MAX_MAP_DIM);
	assign rows_eff = clamp_cfg(map_rows_q, MAX_MAP_DIM);
	assign ts_eff   = clamp_cfg(tile_size_q, CFG_LIMIT);
	assign ac_eff   = clamp_cfg(atlas_cols_q, CFG_LIMIT);

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign in_accept  = in_valid && in_ready;

	assign row_next = (CNT_W+1)'(row_cnt_q) + (CNT_W+1)'(1);
	assign col_next = (CNT_W+1)'(col_cnt_q) + (CNT_W+1)'(1);

	// Configuration registers and the tile walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q   <= W_CFG'(1);
			map_rows_q   <= W_CFG'(1);
			tile_size_q  <= W_CFG'(16);
			atlas_cols_q <= W_CFG'(1);
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
		end else if (cfg_accept) begin
			unique case (cfg_index)
				CFG_MAP_COLUMNS: begin
					map_cols_q <= cfg_data;
					col_cnt_q  <= '0;
					row_cnt_q  <= '0;
				end
				CFG_MAP_ROWS: begin
					map_rows_q <= cfg_data;
					col_cnt_q  <= '0;
					row_cnt_q  <= '0;
				end
				CFG_TILE_SIZE:     tile_size_q  <= cfg_data;
				CFG_ATLAS_COLUMNS: atlas_cols_q <= cfg_data;
				default: ;
			endcase
		end else if (in_accept) begin
			if (32'(row_next) >= 32'(rows_eff)) begin
				row_cnt_q <= '0;
				col_cnt_q <= (32'(col_next) >= 32'(cols_eff)) ? '0 : CNT_W'(col_next);
			end else begin
				row_cnt_q <= CNT_W'(row_next);
			end
		end
	end

	// Hold the tile position and kind for the whole item
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_col_q <= col_cnt_q;
			item_row_q <= row_cnt_q;
			empty_q    <= tile_id[W_ID-1];
		end
	end

	tmqg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.dividend  (W_QUO'(tile_id)),
		.divisor   (ac_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Issue one multiplier pass a cycle while in the multiply phase
	assign issue.valid = (state_q == S_MUL) && (step_q != NUM_OPS);
	assign issue.op    = mul_op_t'(step_q);

	tmqg_mul #(
		.CNT_W (CNT_W)
	) u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.col        (item_col_q),
		.row        (item_row_q),
		.tu         (div_rem),
		.tv         (div_quo),
		.cols       (cols_eff),
		.ts         (ts_eff),
		.tag_s1     (mul_tag),
		.product_s1 (mul_prod)
	);

	// Capture products into the per-tile base values
	always_ff @(posedge clk) begin
		if (mul_tag.valid) begin
			case (mul_tag.op)
				OP_ROW_COLS: base_q  <= BASE_W'(PW'(item_col_q) + mul_prod);
				OP_COL_TS:   px_q    <= W_POS'(mul_prod);
				OP_ROW_TS:   py_q    <= W_POS'(mul_prod);
				OP_TU_TS:    tu_ts_q <= W_TU'(mul_prod);
				OP_TV_TS:    tv_ts_q <= W_TV'(mul_prod);
				default: ;
			endcase
		end
	end

	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			corner_q <= CORNER_TL;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
						step_q  <= '0;
					end
				end
				S_MUL: begin
					if (issue.valid) begin
						step_q <= step_q + 3'd1;
					end
					if (mul_tag.valid && mul_tag.op == OP_TV_TS) begin
						state_q  <= S_EMIT;
						corner_q <= CORNER_TL;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						corner_q <= corner_q + 2'd1;
						if (corner_q == CORNER_BL) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Corner offsets: right edge on TR and BR, bottom edge on BR and BL
	assign dx   = (corner_q == CORNER_TR) || (corner_q == CORNER_BR);
	assign dy   = (corner_q == CORNER_BR) || (corner_q == CORNER_BL);
	assign ts_x = dx ? ts_eff : '0;
	assign ts_y = dy ? ts_eff : '0;

	// Output register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			slot_q    <= {base_q, corner_q};
			pos_x_q   <= px_q + W_POS'(ts_x);
			pos_y_q   <= py_q + W_POS'(ts_y);
			tex_u_q   <= empty_q ? '0 : tu_ts_q + W_TU'(ts_x);
			tex_v_q   <= empty_q ? '0 : tv_ts_q + W_TV'(ts_y);
			visible_q <= !empty_q;
			last_q    <= (corner_q == CORNER_BL);
		end
	end

	assign out_valid   = out_valid_q;
	assign vertex_slot = slot_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign tex_u       = tex_u_q;
	assign tex_v       = tex_v_q;
	assign visible     = visible_q;
	assign last_corner = last_q;

	// The divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

	// Products return only during the multiply phase
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_tag.valid |-> state_q == S_MUL)
		else $error("multiplier result outside the multiply phase");

	// Walk counters stay inside the map
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_cnt_q) < 32'(rows_eff)) && (32'(col_cnt_q) < 32'(cols_eff)))
		else $error("tile walk counter beyond map size");

	// A new tile is taken only once its last corner has been loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && $past(state_q) == S_EMIT |-> $past(emit_load) && $past(corner_q) == CORNER_BL)
		else $error("tile accepted before all corners were issued");

endmodule

>>> design/tmqg_div.sv
module tmqg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tmqg_pkg::W_QUO-1:0]   dividend,
	input  logic [tmqg_pkg::W_CFG-1:0]   divisor,
	output logic                         done,
	output logic [tmqg_pkg::W_QUO-1:0]   quotient,
	output logic [tmqg_pkg::W_REM-1:0]   remainder
);
	import tmqg_pkg::*;

	localparam int CNT_W = $clog2(W_QUO + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W_QUO-1:0] quo_q;
	logic [W_REM-1:0] rem_q;
	logic [W_REM:0]   trial;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[W_QUO-1]};
	assign fits  = trial >= (W_REM+1)'(divisor);

	// Step control: one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(W_QUO);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W_QUO-2:0], fits};
			rem_q <= fits ? W_REM'(trial - (W_REM+1)'(divisor)) : W_REM'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> design/tmqg_mul.sv
module tmqg_mul #(
	parameter  int CNT_W = 8,
	localparam int AW    = (CNT_W > tmqg_pkg::W_QUO) ? CNT_W : tmqg_pkg::W_QUO,
	localparam int PW    = AW + tmqg_pkg::W_CFG
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tmqg_pkg::mul_tag_t           issue,
	input  logic [CNT_W-1:0]             col,
	input  logic [CNT_W-1:0]             row,
	input  logic [tmqg_pkg::W_REM-1:0]   tu,
	input  logic [tmqg_pkg::W_QUO-1:0]   tv,
	input  logic [tmqg_pkg::W_CFG-1:0]   cols,
	input  logic [tmqg_pkg::W_CFG-1:0]   ts,
	output tmqg_pkg::mul_tag_t           tag_s1,
	output logic [PW-1:0]                product_s1
);
	import tmqg_pkg::*;

	logic [AW-1:0]    a_sel;
	logic [W_CFG-1:0] b_sel;

	// Pick operands for this pass
	always_comb begin
		unique case (issue.op)
			OP_ROW_COLS: begin a_sel = AW'(row); b_sel = cols; end
			OP_COL_TS:   begin a_sel = AW'(col); b_sel = ts;   end
			OP_ROW_TS:   begin a_sel = AW'(row); b_sel = ts;   end
			OP_TU_TS:    begin a_sel = AW'(tu);  b_sel = ts;   end
			OP_TV_TS:    begin a_sel = AW'(tv);  b_sel = ts;   end
			default:     begin a_sel = '0;       b_sel = '0;   end
		endcase
	end

	// Tag travels with the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		product_s1 <= PW'(a_sel) * PW'(b_sel);
	end

endmodule

>>> tb/sv/tb_tile_map_quad_generator.sv
`timescale 1ns / 100ps

module tb_tile_map_quad_generator;
	import tmqg_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_OFF       = 400;
	localparam int BURST_LEN      = 24;

	localparam logic signed [W_ID-1:0] EMPTY_TILE   = -17'sd1;
	localparam logic signed [W_ID-1:0] MOST_NEG     = -17'sd65536;
	localparam logic signed [W_ID-1:0] TOP_TILE     = 17'sd65535;

	localparam logic [3:0] WR_COLS  = 4'b0001;
	localparam logic [3:0] WR_ROWS  = 4'b0010;
	localparam logic [3:0] WR_TILE  = 4'b0100;
	localparam logic [3:0] WR_ATLAS = 4'b1000;
	localparam logic [3:0] WR_ALL   = 4'b1111;

	typedef struct packed {
		logic [W_SLOT-1:0] slot;
		logic [W_POS-1:0]  x;
		logic [W_POS-1:0]  y;
		logic [W_TU-1:0]   u;
		logic [W_TV-1:0]   v;
		logic              vis;
		logic              last_c;
	} vertex_t;

	// Tracks the tile walk and holds the corner vertices still owed by the block
	class vertex_ledger;
		logic [W_CFG-1:0] reg_cols, reg_rows, reg_tile, reg_atlas;
		int unsigned      walk_col, walk_row;
		vertex_t          expected_corners[$];
		int               errors, tiles, empties, vertices;

		function new();
			reg_cols  = 9'd1;
			reg_rows  = 9'd1;
			reg_tile  = 9'd16;
			reg_atlas = 9'd1;
			walk_col  = 0;
			walk_row  = 0;
			errors    = 0;
			tiles     = 0;
			empties   = 0;
			vertices  = 0;
		endfunction

		task report(string msg);
			if (errors < 50) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
			errors++;
		endtask

		// Zero acts as one, anything above the limit is cut to it
		function int unsigned effective(logic [W_CFG-1:0] raw, int unsigned hi);
			int unsigned r;
			r = raw;
			if (r == 0) begin
				r = 1;
			end else if (r > hi) begin
				r = hi;
			end
			return r;
		endfunction

		function void set_reg(logic [W_IDX-1:0] idx, logic [W_CFG-1:0] data);
			case (idx)
				CFG_MAP_COLUMNS: begin
					reg_cols = data;
					walk_col = 0;
					walk_row = 0;
				end
				CFG_MAP_ROWS: begin
					reg_rows = data;
					walk_col = 0;
					walk_row = 0;
				end
				CFG_TILE_SIZE: reg_tile = data;
				CFG_ATLAS_COLUMNS: reg_atlas = data;
				default: ;
			endcase
		endfunction

		// Work out the four corners of one accepted tile, then advance the walk
		function void note_tile(logic signed [W_ID-1:0] id);
			int unsigned cols, rows, ts, ac, tu, tv, dx, dy, raw;
			logic        empty;
			logic [63:0] wide;
			logic [1:0]  corner;
			vertex_t     vx;
			cols  = effective(reg_cols, 256);
			rows  = effective(reg_rows, 256);
			ts    = effective(reg_tile, CFG_LIMIT);
			ac    = effective(reg_atlas, CFG_LIMIT);
			empty = id[W_ID-1];
			raw   = {15'd0, id};
			tu    = 0;
			tv    = 0;
			if (!empty) begin
				tu = raw % ac;
				tv = raw / ac;
			end
			tiles++;
			if (empty) begin
				empties++;
			end
			for (int k = 0; k < 4; k++) begin
				corner = 2'(k);
				dx = (corner == CORNER_TR || corner == CORNER_BR) ? 1 : 0;
				dy = (corner == CORNER_BR || corner == CORNER_BL) ? 1 : 0;
				wide = 64'((walk_col + walk_row * cols) * 4 + k);
				vx.slot = wide[W_SLOT-1:0];
				wide = 64'((walk_col + dx) * ts);
				vx.x = wide[W_POS-1:0];
				wide = 64'((walk_row + dy) * ts);
				vx.y = wide[W_POS-1:0];
				wide = 64'((tu + dx) * ts);
				vx.u = empty ? '0 : wide[W_TU-1:0];
				wide = 64'((tv + dy) * ts);
				vx.v = empty ? '0 : wide[W_TV-1:0];
				vx.vis = !empty;
				vx.last_c = (corner == CORNER_BL);
				expected_corners.push_back(vx);
			end
			walk_row++;
			if (walk_row >= rows) begin
				walk_row = 0;
				walk_col++;
				if (walk_col >= cols) begin
					walk_col = 0;
				end
			end
		endfunction

		// Compare one delivered vertex against the oldest one owed
		task check_vertex(vertex_t got);
			vertex_t want;
			if (expected_corners.size() == 0) begin
				report($sformatf("vertex slot %0d arrived with none outstanding", got.slot));
			end else begin
				want = expected_corners.pop_front();
				vertices++;
				if (got.slot !== want.slot)
					report($sformatf("vertex_slot got %0d want %0d", got.slot, want.slot));
				if (got.x !== want.x)
					report($sformatf("pos_x slot %0d got %0d want %0d", want.slot, got.x, want.x));
				if (got.y !== want.y)
					report($sformatf("pos_y slot %0d got %0d want %0d", want.slot, got.y, want.y));
				if (got.u !== want.u)
					report($sformatf("tex_u slot %0d got %0d want %0d", want.slot, got.u, want.u));
				if (got.v !== want.v)
					report($sformatf("tex_v slot %0d got %0d want %0d", want.slot, got.v, want.v));
				if (got.vis !== want.vis)
					report($sformatf("visible slot %0d got %0b want %0b", want.slot, got.vis,
						want.vis));
				if (got.last_c !== want.last_c)
					report($sformatf("last_corner slot %0d got %0b want %0b", want.slot,
						got.last_c, want.last_c));
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [W_IDX-1:0]        cfg_index = '0;
	logic [W_CFG-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [W_ID-1:0]  tile_id = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [W_SLOT-1:0]       vertex_slot;
	logic [W_POS-1:0]        pos_x;
	logic [W_POS-1:0]        pos_y;
	logic [W_TU-1:0]         tex_u;
	logic [W_TV-1:0]         tex_v;
	logic                    visible;
	logic                    last_corner;

	vertex_ledger ledger = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int idle_count     = 0;
	int settings_run   = 0;

	tile_map_quad_generator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tile_id     (tile_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.vertex_slot (vertex_slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.visible     (visible),
		.last_corner (last_corner)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset low from time zero, then release it
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: long hold-off when asked, otherwise random stalls
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watch the three channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				ledger.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				ledger.note_tile(tile_id);
			if (out_valid && out_ready)
				ledger.check_vertex({vertex_slot, pos_x, pos_y, tex_u, tex_v, visible,
					last_corner});
		end
	end

	// Abort when no request moves for too long
	always @(posedge clk) begin
		if (arst_n && !((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready))) begin
			idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end else begin
			idle_count <= 0;
		end
	end

	// Step past the current edge first, so a tile taken on it is already owed
	task automatic wait_drained();
		@(posedge clk);
		while (ledger.expected_corners.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one tile, leaving valid high on return
	task automatic send_tile(logic signed [W_ID-1:0] id);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		tile_id  <= id;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [W_IDX-1:0] idx, logic [W_CFG-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain, then write the selected registers while the block is idle
	task automatic configure(logic [3:0] sel, logic [W_CFG-1:0] cols, logic [W_CFG-1:0] rows,
			logic [W_CFG-1:0] tsize, logic [W_CFG-1:0] atlas);
		wait_drained();
		if (sel[0]) write_reg(CFG_MAP_COLUMNS, cols);
		if (sel[1]) write_reg(CFG_MAP_ROWS, rows);
		if (sel[2]) write_reg(CFG_TILE_SIZE, tsize);
		if (sel[3]) write_reg(CFG_ATLAS_COLUMNS, atlas);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic signed [W_ID-1:0] pick_tile();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return EMPTY_TILE;
		else if (r < 18)
			return {1'b1, 16'($urandom)};
		else if (r < 22)
			return TOP_TILE;
		else if (r < 26)
			return 17'($urandom_range(0, 300));
		else
			return 17'($urandom_range(0, 65535));
	endfunction

	// Random tiles, rotating the idling pattern every burst
	task automatic run_tiles(int n, int mode_base);
		int mode;
		for (int k = 0; k < n; k++) begin
			mode = (mode_base + k / BURST_LEN) % 4;
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			send_tile(pick_tile());
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Reset settings: field extremes, empty and other negative tiles
		send_tile(EMPTY_TILE);
		send_tile(17'sd0);
		send_tile(TOP_TILE);
		send_tile(MOST_NEG);
		send_tile(-17'sd2);
		send_tile(17'sd1);
		send_tile(17'sd4095);
		in_valid <= 1'b0;

		// Zero in every register acts as one
		configure(WR_ALL, 9'd0, 9'd0, 9'd0, 9'd0);
		send_tile(TOP_TILE);
		send_tile(-17'sd300);
		send_tile(17'sd7);
		send_tile(17'sd0);
		in_valid <= 1'b0;

		// Largest plain settings
		configure(WR_ALL, 9'd256, 9'd256, 9'd256, 9'd256);
		send_tile(TOP_TILE);
		send_tile(17'sd255);
		send_tile(17'sd256);
		send_tile(17'sd0);
		send_tile(EMPTY_TILE);
		in_valid <= 1'b0;

		configure(WR_ALL, 9'd5, 9'd3, 9'd16, 9'd16);
		run_tiles(60, 0);

		// Oversized registers; one full row of 256 columns wraps the walk
		configure(WR_ALL, 9'd511, 9'd1, 9'd511, 9'd511);
		run_tiles(260, 1);

		// Tall texture coordinates, with the receiver holding off at the start
		configure(WR_ALL, 9'd1, 9'd7, 9'd256, 9'd1);
		hold_left = HOLD_OFF;
		run_tiles(50, 2);

		// Row count changes without the column count, with tile size and atlas width, then column count alone
		configure(WR_ROWS | WR_TILE | WR_ATLAS, 9'd0, 9'd4, 9'd3, 9'd100);
		run_tiles(50, 3);
		configure(WR_COLS, 9'd17, 9'd0, 9'd0, 9'd0);
		run_tiles(50, 0);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.expected_corners.size() != 0)
			ledger.report($sformatf("%0d vertices never arrived",
				ledger.expected_corners.size()));

		$display("Walked %0d tiles (%0d empty) over %0d register settings plus reset values",
			ledger.tiles, ledger.empties, settings_run);
		$display("Checked %0d vertices field by field, %0d mismatches", ledger.vertices,
			ledger.errors);
		if (ledger.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
